@@ hdl/lcd_4bit_parallel_sequencer_top_assert.svh @@
// assertion macros shared by the lcd sequencer checker
`ifndef LCD_4BIT_PARALLEL_SEQUENCER_TOP_ASSERT_SVH
`define LCD_4BIT_PARALLEL_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during rst
`define LCD4_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet during rst
`define LCD4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lcd4_pkg.sv @@
// shared types, constants and tables of the lcd sequencer
package lcd4_pkg;

  localparam int TICK_W      = 16;
  localparam int CFG_INDEX_W = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_CMD     = 2'd1,
    OP_DATA    = 2'd2,
    OP_CURSOR  = 2'd3
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_EN_HIGH   = 4'd0,
    CFG_EN_LOW    = 4'd1,
    CFG_BYTE_WAIT = 4'd2,
    CFG_POWERUP   = 4'd3
  } cfg_idx_t;

  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [TICK_W-1:0] FINAL_WAIT = 16'd2;
  localparam logic [3:0] STEP_CMDS  = 4'd4;
  localparam logic [3:0] STEP_FINAL = 4'd8;
  localparam logic [3:0] STEP_DONE  = 4'd9;

  localparam logic [TICK_W-1:0] RST_EN_HIGH   = 16'd1;
  localparam logic [TICK_W-1:0] RST_EN_LOW    = 16'd1;
  localparam logic [TICK_W-1:0] RST_BYTE_WAIT = 16'd2;
  localparam logic [TICK_W-1:0] RST_POWERUP   = 16'd20;

  // one queued transaction: either a tick or a byte ready to send
  typedef struct packed {
    logic       is_tick;
    logic       rs;
    logic [7:0] data;
  } entry_t;

  function automatic logic [3:0] init_nibble(input logic [1:0] idx);
    logic [3:0] v;
    case (idx)
      2'd3:    v = 4'h2;
      default: v = 4'h3;
    endcase
    return v;
  endfunction

  function automatic logic [TICK_W-1:0] init_gap(input logic [1:0] idx);
    logic [TICK_W-1:0] v;
    case (idx)
      2'd0:    v = 16'd5;
      2'd1:    v = 16'd5;
      2'd2:    v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] init_cmd(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = 8'h28;
      2'd1:    v = 8'h0C;
      2'd2:    v = 8'h06;
      default: v = 8'h01;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] row_base(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = 8'h00;
      2'd1:    v = 8'h40;
      2'd2:    v = 8'h14;
      default: v = 8'h54;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/lcd4_front.sv @@
// front end: accepts transactions and turns requests into bytes to send
module lcd4_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [7:0]         byte_value,
  input  logic [2:0]         row,
  input  logic [5:0]         col,
  input  logic               q_full,
  output logic               push,
  output lcd4_pkg::entry_t   push_entry
);
  import lcd4_pkg::*;

  logic [7:0] cursor_addr;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // rows past the fourth line fall back to address zero
  always_comb begin
    if (row inside {[3'd0:3'd3]}) begin
      cursor_addr = row_base(row[1:0]) + {2'b00, col};
    end else begin
      cursor_addr = 8'h00;
    end
  end

  always_comb begin
    push_entry.is_tick = 1'b0;
    push_entry.rs      = 1'b0;
    push_entry.data    = byte_value;
    case (op_t'(opcode))
      OP_TICK: begin
        push_entry.is_tick = 1'b1;
      end
      OP_CMD: begin
        push_entry.rs = 1'b0;
      end
      OP_DATA: begin
        push_entry.rs = 1'b1;
      end
      OP_CURSOR: begin
        push_entry.data = CMD_SET_ADDR | cursor_addr;
      end
      default: begin
        push_entry.is_tick = 1'b1;
      end
    endcase
  end

endmodule

@@ hdl/lcd4_queue.sv @@
// short fifo between front end and sequencer
module lcd4_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lcd4_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output lcd4_pkg::entry_t q_entry
);
  import lcd4_pkg::*;

  entry_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/lcd4_back.sv @@
// back end: timing sequencer, config registers and result register
module lcd4_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lcd4_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lcd4_pkg::TICK_W-1:0]        cfg_data,
  input  logic                               q_valid,
  input  lcd4_pkg::entry_t                   q_entry,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               reg_select,
  output logic                               enable_pin,
  output logic [3:0]                         bus_nibble,
  output logic                               busy_res,
  output logic                               rejected,
  output logic                               init_done
);
  import lcd4_pkg::*;

  typedef enum logic [2:0] {
    PH_POWERUP,
    PH_EN_HIGH,
    PH_EN_LOW,
    PH_INIT_WAIT,
    PH_BYTE_WAIT,
    PH_IDLE
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic [3:0]        init_step;
    logic [TICK_W-1:0] remaining;
    logic [7:0]        held_byte;
    logic              low_half;
    logic              pin_rs;
    logic              pin_en;
    logic [3:0]        pin_nibble;
  } seq_t;

  logic [TICK_W-1:0] enable_high_ticks;
  logic [TICK_W-1:0] enable_low_ticks;
  logic [TICK_W-1:0] byte_wait_ticks;
  logic [TICK_W-1:0] hi_eff;
  logic [TICK_W-1:0] lo_eff;

  seq_t state;
  seq_t state_next;
  seq_t restart_next;
  logic rej_next;
  logic restart;

  function automatic seq_t start_byte(input seq_t s, input logic rs, input logic [7:0] b,
                                      input logic [TICK_W-1:0] hi);
    seq_t r;
    r            = s;
    r.held_byte  = b;
    r.pin_rs     = rs;
    r.pin_nibble = b[7:4];
    r.pin_en     = 1'b1;
    r.low_half   = 1'b1;
    r.phase      = PH_EN_HIGH;
    r.remaining  = hi;
    return r;
  endfunction

  function automatic seq_t run_init(input seq_t s, input logic [TICK_W-1:0] hi);
    seq_t r;
    r = s;
    if (s.init_step < STEP_CMDS) begin
      r.pin_rs     = 1'b0;
      r.pin_nibble = init_nibble(s.init_step[1:0]);
      r.pin_en     = 1'b1;
      r.low_half   = 1'b0;
      r.phase      = PH_EN_HIGH;
      r.remaining  = hi;
    end else if (s.init_step < STEP_FINAL) begin
      r = start_byte(s, 1'b0, init_cmd(s.init_step[1:0]), hi);
    end else if (s.init_step == STEP_FINAL) begin
      r.phase     = PH_INIT_WAIT;
      r.remaining = FINAL_WAIT;
    end else begin
      r.init_step = STEP_DONE;
      r.phase     = PH_IDLE;
      r.remaining = '0;
    end
    return r;
  endfunction

  // end of the wait after a byte: next init step or back to idle
  function automatic seq_t byte_wait_done(input seq_t s, input logic [TICK_W-1:0] hi);
    seq_t r;
    r = s;
    if (s.init_step < STEP_DONE) begin
      r.init_step = s.init_step + 4'd1;
      r = run_init(r, hi);
    end else begin
      r.phase = PH_IDLE;
    end
    return r;
  endfunction

  // interval ran out; zero-length waits collapse into the same cycle
  function automatic seq_t expire(input seq_t s, input logic [TICK_W-1:0] hi,
                                  input logic [TICK_W-1:0] lo,
                                  input logic [TICK_W-1:0] bw);
    seq_t r;
    logic [TICK_W-1:0] gap;
    r   = s;
    gap = init_gap(s.init_step[1:0]);
    case (s.phase)
      PH_POWERUP: begin
        r = run_init(s, hi);
      end
      PH_EN_HIGH: begin
        r.pin_en    = 1'b0;
        r.phase     = PH_EN_LOW;
        r.remaining = lo;
      end
      PH_EN_LOW: begin
        if (s.low_half) begin
          r.low_half   = 1'b0;
          r.pin_nibble = s.held_byte[3:0];
          r.pin_en     = 1'b1;
          r.phase      = PH_EN_HIGH;
          r.remaining  = hi;
        end else if (s.init_step < STEP_CMDS) begin
          if (gap == '0) begin
            r.init_step = s.init_step + 4'd1;
            r = run_init(r, hi);
          end else begin
            r.phase     = PH_INIT_WAIT;
            r.remaining = gap;
          end
        end else if (bw == '0) begin
          r = byte_wait_done(s, hi);
        end else begin
          r.phase     = PH_BYTE_WAIT;
          r.remaining = bw;
        end
      end
      PH_INIT_WAIT: begin
        r.init_step = s.init_step + 4'd1;
        r = run_init(r, hi);
      end
      PH_BYTE_WAIT: begin
        r = byte_wait_done(s, hi);
      end
      default: begin
        r.phase = PH_IDLE;
      end
    endcase
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign hi_eff    = (enable_high_ticks == '0) ? TICK_W'(1) : enable_high_ticks;
  assign lo_eff    = (enable_low_ticks == '0) ? TICK_W'(1) : enable_low_ticks;
  assign pop       = q_valid && (!out_valid || !out_stall);
  assign restart   = cfg_valid && (cfg_index == CFG_POWERUP) && (state.phase == PH_POWERUP);

  always_comb begin
    state_next = state;
    rej_next   = 1'b0;
    if (q_entry.is_tick) begin
      if (state.phase != PH_IDLE) begin
        if (state.remaining > TICK_W'(1)) begin
          state_next.remaining = state.remaining - TICK_W'(1);
        end else begin
          state_next.remaining = '0;
          state_next = expire(state_next, hi_eff, lo_eff, byte_wait_ticks);
        end
      end
    end else if (state.phase != PH_IDLE) begin
      rej_next = 1'b1;
    end else begin
      state_next = start_byte(state, q_entry.rs, q_entry.data, hi_eff);
    end
  end

  always_comb begin
    restart_next           = state;
    restart_next.phase     = PH_POWERUP;
    restart_next.remaining = cfg_data;
    if (cfg_data == '0) begin
      restart_next = run_init(restart_next, hi_eff);
    end
  end

  // the power-up count acts only through the restart path
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_high_ticks <= RST_EN_HIGH;
      enable_low_ticks  <= RST_EN_LOW;
      byte_wait_ticks   <= RST_BYTE_WAIT;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_EN_HIGH:   enable_high_ticks <= cfg_data;
        CFG_EN_LOW:    enable_low_ticks  <= cfg_data;
        CFG_BYTE_WAIT: byte_wait_ticks   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= PH_POWERUP;
      state.init_step  <= '0;
      state.remaining  <= RST_POWERUP;
      state.held_byte  <= '0;
      state.low_half   <= 1'b0;
      state.pin_rs     <= 1'b0;
      state.pin_en     <= 1'b0;
      state.pin_nibble <= '0;
    end else if (restart) begin
      state <= restart_next;
    end else if (pop) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      reg_select <= state_next.pin_rs;
      enable_pin <= state_next.pin_en;
      bus_nibble <= state_next.pin_nibble;
      busy_res   <= (state_next.phase != PH_IDLE);
      rejected   <= rej_next;
      init_done  <= (state_next.init_step >= STEP_DONE);
    end
  end

endmodule

@@ hdl/lcd_4bit_parallel_sequencer_top.sv @@
// top level of the 4-bit character lcd sequencer
//
// usage:
// - input channel (in_valid/in_stall) carries one transaction per item:
//   opcode 0 is a 1 ms tick, 1 sends a command byte, 2 a data byte,
//   3 a set-cursor request built from row and col
// - output channel (out_valid/out_stall) returns exactly one transaction
//   per input item with the pin levels (rs, en, d7..d4, rw) after the item,
//   plus busy, rejected and init_done flags
// - config channel (cfg_valid/cfg_ready, always ready) writes enable high,
//   enable low, byte wait and power-up tick counts by index 0..3; write it
//   only while no transactions are in flight
// - after reset the power-up sequence runs on ticks alone; requests that
//   arrive before it finishes, or during any byte transfer, come back
//   with rejected set
// - out_valid rises once an item has passed queue and result register;
//   one item per cycle unless stalled, each one sequencer state update
// - when the receiver stalls the result register holds; the two-entry
//   queue between front and back end keeps taking items until it fills,
//   then in_stall rises
module lcd_4bit_parallel_sequencer_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        opcode,
  input  logic [7:0]                        byte_value,
  input  logic [2:0]                        row,
  input  logic [5:0]                        col,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              reg_select,
  output logic                              enable_pin,
  output logic [3:0]                        bus_nibble,
  output logic                              read_write,
  output logic                              busy_res,
  output logic                              rejected,
  output logic                              init_done,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lcd4_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lcd4_pkg::TICK_W-1:0]       cfg_data
);
  import lcd4_pkg::*;

  // front end to queue
  logic   push;
  entry_t push_entry;
  logic   q_full;

  // queue to back end
  logic   q_valid;
  entry_t q_entry;
  logic   pop;

  // only writes are ever issued to the display
  assign read_write = 1'b0;

  lcd4_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .byte_value (byte_value),
    .row        (row),
    .col        (col),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  lcd4_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  // sequencer: pin timing, init steps, rejection of busy requests
  lcd4_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .reg_select (reg_select),
    .enable_pin (enable_pin),
    .bus_nibble (bus_nibble),
    .busy_res   (busy_res),
    .rejected   (rejected),
    .init_done  (init_done)
  );

endmodule

@@ hdl/lcd4_checker.sv @@
// port-level checks of the lcd sequencer and their bind
`include "lcd_4bit_parallel_sequencer_top_assert.svh"

module lcd4_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       enable_pin,
  input logic [3:0] bus_nibble,
  input logic       read_write,
  input logic       busy_res,
  input logic       rejected,
  input logic       init_done
);

  `LCD4_ASSERT_SAME(a_rej_busy, out_valid && rejected, busy_res, "rejected while not busy")
  `LCD4_ASSERT_SAME(a_init_busy, out_valid && !init_done, busy_res && !read_write, "idle before init done")
  `LCD4_ASSERT_SAME(a_en_busy, out_valid && enable_pin, busy_res, "enable high while idle")
  `LCD4_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(bus_nibble), "stalled result moved")

endmodule

bind lcd_4bit_parallel_sequencer_top lcd4_checker u_checker (.*);

@@ tb/lcd_4bit_parallel_sequencer_top_tb.sv @@
// self-checking testbench for the 4-bit character lcd sequencer top level
module lcd_4bit_parallel_sequencer_top_tb;
  import lcd4_pkg::*;

  // run limits
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PRINT_CAP     = 60;

  // power-up and cursor tables; init ones hold one lane per init step
  localparam logic [15:0] INIT_NIBS     = 16'h2333;
  localparam logic [15:0] INIT_GAPS     = 16'h0155;
  localparam logic [31:0] INIT_CMDS     = 32'h01060C28;
  localparam logic [31:0] ROW_BASES     = 32'h54144000;
  localparam logic [7:0]  SET_DDRAM     = 8'h80;
  localparam logic [15:0] FINAL_GAP     = 16'd2;
  localparam logic [3:0]  STEP_FINISHED = 4'd9;
  localparam logic [3:0]  FIRST_CMD     = 4'd4;
  localparam logic [3:0]  LAST_CMD_END  = 4'd8;
  // config index with no register behind it
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 4'd9;

  typedef enum logic [2:0] {
    ST_POWER_WAIT,
    ST_STROBE_HIGH,
    ST_STROBE_LOW,
    ST_INIT_GAP,
    ST_BYTE_GAP,
    ST_IDLE
  } seq_state_e;

  // one input transaction
  typedef struct packed {
    op_t        op;
    logic [7:0] b;
    logic [2:0] r;
    logic [5:0] c;
  } req_t;

  // one output transaction
  typedef struct packed {
    logic       rs;
    logic       en;
    logic [3:0] nib;
    logic       rw;
    logic       busy;
    logic       rej;
    logic       done;
  } pin_levels_t;

  // dut ports, driven inputs known from time zero
  logic                   clk;
  logic                   rst        = 1'b1;
  logic                   in_valid   = 1'b0;
  logic                   in_stall;
  logic [1:0]             opcode     = '0;
  logic [7:0]             byte_value = '0;
  logic [2:0]             row        = '0;
  logic [5:0]             col        = '0;
  logic                   out_valid;
  logic                   out_stall  = 1'b0;
  logic                   reg_select;
  logic                   enable_pin;
  logic [3:0]             bus_nibble;
  logic                   read_write;
  logic                   busy_res;
  logic                   rejected;
  logic                   init_done;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [TICK_W-1:0]      cfg_data   = '0;

  // traffic shaping, percent of cycles
  int send_gap_pct = 0;
  int stall_pct    = 0;

  // stimulus and expectation stores
  req_t        todo_reqs[$];
  pin_levels_t pins_due[$];
  req_t        cur_req;
  int          mismatches = 0;
  int          cycles     = 0;

  // sequencer state as predicted
  logic [15:0] cfg_en_high, cfg_en_low, cfg_byte_wait, cfg_powerup;
  seq_state_e  st;
  logic [3:0]  init_step;
  logic [15:0] ticks_left;
  logic [7:0]  byte_held;
  logic        low_half_due;
  logic        pin_rs, pin_en;
  logic [3:0]  pin_nib;

  lcd_4bit_parallel_sequencer_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .byte_value (byte_value),
    .row        (row),
    .col        (col),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .reg_select (reg_select),
    .enable_pin (enable_pin),
    .bus_nibble (bus_nibble),
    .read_write (read_write),
    .busy_res   (busy_res),
    .rejected   (rejected),
    .init_done  (init_done),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // sequencer prediction
  // ---------------------------------------------------------------

  // zero enable times behave like one tick
  function automatic logic [15:0] at_least_1(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  // load an interval; zero-length ones are expired by settle()
  function automatic void arm(input seq_state_e s, input logic [15:0] n);
    st         = s;
    ticks_left = n;
  endfunction

  // put the high nibble of a byte on the bus with en raised
  function automatic void strobe_byte(input logic rs, input logic [7:0] b);
    byte_held    = b;
    pin_rs       = rs;
    pin_nib      = b[7:4];
    pin_en       = 1'b1;
    low_half_due = 1'b1;
    arm(ST_STROBE_HIGH, at_least_1(cfg_en_high));
  endfunction

  // action for the current power-up step
  function automatic void next_init_action();
    if (init_step < FIRST_CMD) begin
      // lone init nibbles, rs low
      pin_rs       = 1'b0;
      pin_nib      = INIT_NIBS[init_step*4 +: 4];
      pin_en       = 1'b1;
      low_half_due = 1'b0;
      arm(ST_STROBE_HIGH, at_least_1(cfg_en_high));
    end else if (init_step < LAST_CMD_END) begin
      strobe_byte(1'b0, INIT_CMDS[(init_step-FIRST_CMD)*8 +: 8]);
    end else if (init_step == LAST_CMD_END) begin
      arm(ST_INIT_GAP, FINAL_GAP);
    end else begin
      init_step  = STEP_FINISHED;
      st         = ST_IDLE;
      ticks_left = 16'd0;
    end
  endfunction

  // end of the running interval
  function automatic void on_expiry();
    case (st)
      ST_POWER_WAIT: next_init_action();
      ST_STROBE_HIGH: begin
        pin_en = 1'b0;
        arm(ST_STROBE_LOW, at_least_1(cfg_en_low));
      end
      ST_STROBE_LOW: begin
        if (low_half_due) begin
          low_half_due = 1'b0;
          pin_nib      = byte_held[3:0];
          pin_en       = 1'b1;
          arm(ST_STROBE_HIGH, at_least_1(cfg_en_high));
        end else if (init_step < FIRST_CMD) begin
          arm(ST_INIT_GAP, {12'd0, INIT_GAPS[init_step*4 +: 4]});
        end else begin
          arm(ST_BYTE_GAP, cfg_byte_wait);
        end
      end
      ST_INIT_GAP: begin
        init_step = init_step + 4'd1;
        next_init_action();
      end
      ST_BYTE_GAP: begin
        if (init_step < STEP_FINISHED) begin
          init_step = init_step + 4'd1;
          next_init_action();
        end else begin
          st = ST_IDLE;
        end
      end
      default: st = ST_IDLE;
    endcase
  endfunction

  // zero-length intervals chain through at once
  function automatic void settle();
    while (st != ST_IDLE && ticks_left == 16'd0)
      on_expiry();
  endfunction

  function automatic void model_reset();
    cfg_en_high   = 16'd1;
    cfg_en_low    = 16'd1;
    cfg_byte_wait = 16'd2;
    cfg_powerup   = 16'd20;
    init_step     = 4'd0;
    byte_held     = 8'd0;
    low_half_due  = 1'b0;
    pin_rs        = 1'b0;
    pin_en        = 1'b0;
    pin_nib       = 4'd0;
    arm(ST_POWER_WAIT, cfg_powerup);
    settle();
  endfunction

  // register write as seen by the sequencer
  function automatic void note_cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [15:0] val);
    case (idx)
      CFG_EN_HIGH:   cfg_en_high   = val;
      CFG_EN_LOW:    cfg_en_low    = val;
      CFG_BYTE_WAIT: cfg_byte_wait = val;
      CFG_POWERUP: begin
        cfg_powerup = val;
        // a new power-up count restarts a wait that is still running
        if (st == ST_POWER_WAIT) begin
          arm(ST_POWER_WAIT, val);
          settle();
        end
      end
      default: ;
    endcase
  endfunction

  // advance the sequencer by one transaction and return the pin levels
  function automatic pin_levels_t pin_levels_after(input req_t q);
    pin_levels_t p;
    logic        dropped;
    logic [7:0]  addr;
    dropped = 1'b0;
    if (q.op == OP_TICK) begin
      if (st != ST_IDLE) begin
        if (ticks_left > 16'd1) begin
          ticks_left = ticks_left - 16'd1;
        end else begin
          ticks_left = 16'd0;
          settle();
        end
      end
    end else if (st != ST_IDLE) begin
      dropped = 1'b1;
    end else if (q.op == OP_CMD) begin
      strobe_byte(1'b0, q.b);
    end else if (q.op == OP_DATA) begin
      strobe_byte(1'b1, q.b);
    end else begin
      // rows past the fourth select address zero
      addr = (q.r < 3'd4) ? ROW_BASES[q.r[1:0]*8 +: 8] + {2'b00, q.c} : 8'd0;
      strobe_byte(1'b0, SET_DDRAM | addr);
    end
    p.rs   = pin_rs;
    p.en   = pin_en;
    p.nib  = pin_nib;
    p.rw   = 1'b0;
    p.busy = (st != ST_IDLE);
    p.rej  = dropped;
    p.done = (init_step >= STEP_FINISHED);
    return p;
  endfunction

  // ---------------------------------------------------------------
  // driver: presents queued transactions, predicts on acceptance
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        pins_due.push_back(pin_levels_after(cur_req));
      // a held payload stays put until it is taken
      if (!in_valid || !in_stall) begin
        if (todo_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          cur_req    = todo_reqs.pop_front();
          opcode     <= cur_req.op;
          byte_value <= cur_req.b;
          row        <= cur_req.r;
          col        <= cur_req.c;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // monitor: random stall, compares each result with the oldest one due
  // ---------------------------------------------------------------
  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    if (mismatches < PRINT_CAP)
      $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  always @(posedge clk) begin
    pin_levels_t got;
    pin_levels_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{reg_select, enable_pin, bus_nibble, read_write, busy_res, rejected,
                init_done};
        if (pins_due.size() == 0) begin
          flag_mismatch("unexpected transaction", {1'b0, got[9:3]}, 8'd0);
        end else begin
          want = pins_due.pop_front();
          if (got.rs !== want.rs)     flag_mismatch("reg_select", got.rs, want.rs);
          if (got.en !== want.en)     flag_mismatch("enable_pin", got.en, want.en);
          if (got.nib !== want.nib)   flag_mismatch("bus_nibble", got.nib, want.nib);
          if (got.rw !== want.rw)     flag_mismatch("read_write", got.rw, want.rw);
          if (got.busy !== want.busy) flag_mismatch("busy_res", got.busy, want.busy);
          if (got.rej !== want.rej)   flag_mismatch("rejected", got.rej, want.rej);
          if (got.done !== want.done) flag_mismatch("init_done", got.done, want.done);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------
  task automatic queue_req(input op_t op, input logic [7:0] b, input logic [2:0] r,
                           input logic [5:0] c);
    req_t q;
    q = '{op, b, r, c};
    todo_reqs.push_back(q);
  endtask

  // random request; ticks carry random payload that must be ignored
  task automatic queue_random(input bit with_tick, input bit only_tick);
    op_t op;
    if (only_tick)
      op = OP_TICK;
    else if (with_tick)
      op = op_t'($urandom_range(3));
    else
      op = op_t'($urandom_range(3, 1));
    queue_req(op, 8'($urandom_range(255)), 3'($urandom_range(7)),
              6'($urandom_range(63)));
  endtask

  // every queued transaction taken and every result back
  task automatic wait_quiet();
    while (todo_reqs.size() != 0 || in_valid || pins_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // feed ticks until the sequencer is predicted idle again
  task automatic run_until_idle();
    wait_quiet();
    while (st != ST_IDLE) begin
      repeat (4) queue_random(1'b0, 1'b1);
      wait_quiet();
    end
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    note_cfg_write(idx, val);
  endtask

  // request then roughly the ticks a byte needs; some runs are cut short
  // so the next request lands while busy, some requests land mid-transfer
  task automatic random_traffic(input int n_items);
    int made;
    int need;
    int k;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(9) == 0) begin
        queue_random(1'b1, 1'b0);
        made++;
      end else begin
        queue_random(1'b0, 1'b0);
        made++;
        need = 2 * int'(at_least_1(cfg_en_high)) + 2 * int'(at_least_1(cfg_en_low))
               + int'(cfg_byte_wait);
        k = ($urandom_range(4) == 0) ? $urandom_range(need) : need + $urandom_range(2);
        repeat (k) begin
          queue_random(1'b0, 1'b1);
          made++;
          if ($urandom_range(7) == 0) begin
            queue_random(1'b0, 1'b0);
            made++;
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------
  initial begin
    int n;
    model_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // longest power-up wait, requests during it come back rejected
    cfg_write(CFG_POWERUP, 16'hFFFF);
    queue_req(OP_TICK, 8'hFF, 3'd7, 6'd63);
    queue_req(OP_CMD, 8'h33, 3'd0, 6'd0);
    queue_req(OP_TICK, 8'h00, 3'd0, 6'd0);
    wait_quiet();

    // zero power-up wait starts the init nibbles at once
    cfg_write(CFG_POWERUP, 16'd0);
    queue_req(OP_DATA, 8'h41, 3'd0, 6'd0);
    queue_req(OP_CURSOR, 8'h00, 3'd2, 6'd9);
    run_until_idle();

    // directed requests at the reset timing
    queue_req(OP_CMD, 8'h00, 3'd0, 6'd0);
    run_until_idle();
    queue_req(OP_DATA, 8'hFF, 3'd0, 6'd0);
    run_until_idle();
    queue_req(OP_CURSOR, 8'h00, 3'd0, 6'd0);
    run_until_idle();
    // column sum past the line base, and wrap into the set-address bit
    queue_req(OP_CURSOR, 8'hFF, 3'd3, 6'd63);
    run_until_idle();
    queue_req(OP_CURSOR, 8'h00, 3'd1, 6'd63);
    run_until_idle();
    queue_req(OP_CURSOR, 8'h00, 3'd2, 6'd5);
    run_until_idle();
    // rows past the last line give address zero
    queue_req(OP_CURSOR, 8'h00, 3'd7, 6'd63);
    run_until_idle();
    queue_req(OP_CURSOR, 8'h00, 3'd4, 6'd1);
    run_until_idle();
    // request on top of a running transfer
    queue_req(OP_DATA, 8'h5A, 3'd0, 6'd0);
    queue_req(OP_CMD, 8'hA5, 3'd0, 6'd0);
    queue_req(OP_TICK, 8'h00, 3'd0, 6'd0);
    queue_req(OP_CURSOR, 8'h00, 3'd1, 6'd1);
    run_until_idle();
    queue_req(OP_TICK, 8'h12, 3'd5, 6'd33);

    // random phase, no idling, byte wait of zero skipped
    wait_quiet();
    cfg_write(CFG_BYTE_WAIT, 16'd0);
    random_traffic(220);

    // sender gaps, zero enable high time acts as one
    wait_quiet();
    cfg_write(CFG_EN_HIGH, 16'd0);
    cfg_write(CFG_EN_LOW, 16'd2);
    cfg_write(CFG_BYTE_WAIT, 16'd3);
    send_gap_pct = 75;
    random_traffic(220);

    // receiver stalls, zero enable low time acts as one
    wait_quiet();
    cfg_write(CFG_EN_HIGH, 16'd3);
    cfg_write(CFG_EN_LOW, 16'd0);
    cfg_write(CFG_BYTE_WAIT, 16'd1);
    send_gap_pct = 0;
    stall_pct    = 75;
    random_traffic(220);

    // both sides pause; power-up write ignored now, spare index ignored
    wait_quiet();
    cfg_write(CFG_EN_HIGH, 16'd2);
    cfg_write(CFG_EN_LOW, 16'd1);
    cfg_write(CFG_BYTE_WAIT, 16'd2);
    cfg_write(CFG_POWERUP, 16'hFFFF);
    cfg_write(CFG_SPARE, 16'd0);
    send_gap_pct = 26;
    stall_pct    = 26;
    random_traffic(220);

    // widest intervals: one transfer that stays busy through the tail
    wait_quiet();
    cfg_write(CFG_EN_HIGH, 16'hFFFF);
    cfg_write(CFG_EN_LOW, 16'hFFFF);
    cfg_write(CFG_BYTE_WAIT, 16'hFFFF);
    queue_random(1'b0, 1'b0);
    repeat (40) queue_random(1'b1, 1'b0);

    // drain, bounded
    n = 0;
    while ((todo_reqs.size() != 0 || in_valid || pins_due.size() != 0)
           && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pins_due.size() != 0)
      flag_mismatch("transactions never returned", 8'(pins_due.size()), 8'd0);

    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/lcd4_pkg.sv
hdl/lcd4_front.sv
hdl/lcd4_queue.sv
hdl/lcd4_back.sv
hdl/lcd_4bit_parallel_sequencer_top.sv
hdl/lcd4_checker.sv
tb/lcd_4bit_parallel_sequencer_top_tb.sv
